// File: hdl/asfp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the ASCII sensor frame parser.
// Depends on nothing; every other file of the block refers to it by scoped names.

package asfp_pkg;

    localparam logic [7:0] HDR_X      = 8'h58;
    localparam logic [7:0] HDR_Y      = 8'h59;
    localparam logic [7:0] HDR_C      = 8'h43;
    localparam logic [7:0] HDR_P      = 8'h50;
    localparam logic [7:0] HDR_S      = 8'h53;
    localparam logic [7:0] DIGIT_ZERO = 8'h30;

    localparam int FRAME_DEPTH = 5;
    localparam int FULL_TURN   = 3600;

    localparam logic [2:0] LEN_XY = 3'd4;
    localparam logic [2:0] LEN_C  = 3'd5;
    localparam logic [2:0] LEN_PS = 3'd1;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 12;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_HEADING_OFFSET = 3'd0,
        REG_WINDOW_X_LOW   = 3'd1,
        REG_WINDOW_X_HIGH  = 3'd2,
        REG_WINDOW_Y_LOW   = 3'd3,
        REG_WINDOW_Y_HIGH  = 3'd4
    } reg_index_t;

    localparam logic [9:0] RST_WINDOW_X_LOW  = 10'd265;
    localparam logic [9:0] RST_WINDOW_X_HIGH = 10'd290;
    localparam logic [9:0] RST_WINDOW_Y_LOW  = 10'd250;
    localparam logic [9:0] RST_WINDOW_Y_HIGH = 10'd280;

    typedef enum logic [2:0] {
        KIND_NONE    = 3'd0,
        KIND_X       = 3'd1,
        KIND_Y       = 3'd2,
        KIND_COMPASS = 3'd3,
        KIND_PLAY    = 3'd4
    } kind_t;

    typedef struct packed {
        logic [11:0] heading_offset;
        logic [9:0]  window_x_low;
        logic [9:0]  window_x_high;
        logic [9:0]  window_y_low;
        logic [9:0]  window_y_high;
    } cfg_t;

    typedef struct packed {
        logic               frame_done;
        kind_t              frame_kind;
        logic signed [15:0] x_coord;
        logic signed [15:0] y_coord;
        logic signed [19:0] heading_tenths;
        logic [7:0]         game_state;
        logic               ball_in_window;
    } result_t;

endpackage

// File: hdl/asfp_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register file: heading offset and the ball window limits.
// Depends on asfp_pkg for the register indexes, reset values and cfg_t.

module asfp_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [asfp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [asfp_pkg::CFG_DATA_W-1:0]    cfg_data,
    output asfp_pkg::cfg_t                     cfg
);

    asfp_pkg::cfg_t cfg_reg;
    asfp_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                asfp_pkg::REG_HEADING_OFFSET: cfg_next.heading_offset = cfg_data;
                asfp_pkg::REG_WINDOW_X_LOW:   cfg_next.window_x_low   = cfg_data[9:0];
                asfp_pkg::REG_WINDOW_X_HIGH:  cfg_next.window_x_high  = cfg_data[9:0];
                asfp_pkg::REG_WINDOW_Y_LOW:   cfg_next.window_y_low   = cfg_data[9:0];
                asfp_pkg::REG_WINDOW_Y_HIGH:  cfg_next.window_y_high  = cfg_data[9:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.heading_offset <= 12'd0;
            cfg_reg.window_x_low   <= asfp_pkg::RST_WINDOW_X_LOW;
            cfg_reg.window_x_high  <= asfp_pkg::RST_WINDOW_X_HIGH;
            cfg_reg.window_y_low   <= asfp_pkg::RST_WINDOW_Y_LOW;
            cfg_reg.window_y_high  <= asfp_pkg::RST_WINDOW_Y_HIGH;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: hdl/asfp_parser.sv
`timescale 1ns / 1ps
// Framing state and single-pass decode of one byte or capture request.
// Depends on asfp_pkg for header codes, frame lengths, cfg_t and result_t.

module asfp_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  logic                 command,
    input  logic [7:0]           rx_byte,
    input  asfp_pkg::cfg_t       cfg,
    output asfp_pkg::result_t    result
);

    logic [7:0]         frame_bytes_reg [asfp_pkg::FRAME_DEPTH];
    logic [2:0]         byte_count_reg;
    logic [2:0]         byte_count_next;
    logic [2:0]         frame_length_reg;
    logic [2:0]         frame_length_next;
    logic signed [15:0] x_value_reg;
    logic signed [15:0] x_value_next;
    logic signed [15:0] y_value_reg;
    logic signed [15:0] y_value_next;
    logic signed [19:0] heading_value_reg;
    logic signed [19:0] heading_value_next;
    logic signed [18:0] raw_heading_reg;
    logic signed [18:0] raw_heading_next;
    logic signed [18:0] captured_offset_reg;
    logic signed [18:0] captured_offset_next;
    logic [7:0]         play_state_reg;
    logic [7:0]         play_state_next;

    logic [2:0]         wr_index;
    logic [7:0]         view [asfp_pkg::FRAME_DEPTH];
    logic [7:0]         hdr;
    logic               is_xy;
    logic               is_c;
    logic               is_ps;
    logic [2:0]         count_step;
    logic [2:0]         length_step;
    logic signed [8:0]  d1;
    logic signed [8:0]  d2;
    logic signed [8:0]  d3;
    logic signed [8:0]  d4;
    logic signed [15:0] three_digits;
    logic signed [21:0] compass_raw;
    logic signed [21:0] corrected;
    logic signed [21:0] wrapped;
    logic               done;
    asfp_pkg::kind_t    kind;

    function automatic logic signed [8:0] digit(input logic [7:0] b);
        digit = $signed({1'b0, b}) - $signed({1'b0, asfp_pkg::DIGIT_ZERO});
    endfunction

    assign wr_index = (byte_count_reg >= 3'(asfp_pkg::FRAME_DEPTH))
                    ? 3'(byte_count_reg - 3'(asfp_pkg::FRAME_DEPTH)) : byte_count_reg;

    always_comb begin
        for (int i = 0; i < asfp_pkg::FRAME_DEPTH; i++) begin
            view[i] = (wr_index == 3'(i)) ? rx_byte : frame_bytes_reg[i];
        end
    end

    assign hdr   = view[0];
    assign is_xy = (hdr == asfp_pkg::HDR_X) || (hdr == asfp_pkg::HDR_Y);
    assign is_c  = (hdr == asfp_pkg::HDR_C);
    assign is_ps = (hdr == asfp_pkg::HDR_P) || (hdr == asfp_pkg::HDR_S);

    assign d1 = digit(view[1]);
    assign d2 = digit(view[2]);
    assign d3 = digit(view[3]);
    assign d4 = digit(view[4]);

    assign three_digits = 16'sd100 * 16'(d1) + 16'sd10 * 16'(d2) + 16'(d3);
    assign compass_raw  = 22'sd1000 * 22'(d1) + 22'sd100 * 22'(d2)
                        + 22'sd10 * 22'(d3) + 22'(d4);
    assign corrected    = compass_raw - $signed({10'd0, cfg.heading_offset})
                        - 22'(captured_offset_reg);

    always_comb begin
        if (corrected < 22'sd0) begin
            wrapped = corrected + 22'(asfp_pkg::FULL_TURN);
        end else if (corrected > 22'(asfp_pkg::FULL_TURN)) begin
            wrapped = corrected - 22'(asfp_pkg::FULL_TURN);
        end else begin
            wrapped = corrected;
        end
    end

    always_comb begin
        byte_count_next      = byte_count_reg;
        frame_length_next    = frame_length_reg;
        x_value_next         = x_value_reg;
        y_value_next         = y_value_reg;
        heading_value_next   = heading_value_reg;
        raw_heading_next     = raw_heading_reg;
        captured_offset_next = captured_offset_reg;
        play_state_next      = play_state_reg;
        done                 = 1'b0;
        kind                 = asfp_pkg::KIND_NONE;
        count_step           = byte_count_reg;
        length_step          = frame_length_reg;

        if (is_xy) begin
            length_step = asfp_pkg::LEN_XY;
            count_step  = byte_count_reg + 3'd1;
        end else if (is_c) begin
            length_step = asfp_pkg::LEN_C;
            count_step  = byte_count_reg + 3'd1;
        end else if (is_ps) begin
            length_step = asfp_pkg::LEN_PS;
            count_step  = byte_count_reg + 3'd1;
        end

        if (accept) begin
            if (command) begin
                captured_offset_next = raw_heading_reg;
            end else begin
                frame_length_next = length_step;
                byte_count_next   = count_step;
                if (count_step == length_step) begin
                    byte_count_next = 3'd0;
                    priority if (hdr == asfp_pkg::HDR_X) begin
                        x_value_next = three_digits;
                        kind         = asfp_pkg::KIND_X;
                    end else if (hdr == asfp_pkg::HDR_Y) begin
                        y_value_next = three_digits;
                        kind         = asfp_pkg::KIND_Y;
                    end else if (is_c) begin
                        raw_heading_next   = compass_raw[18:0];
                        heading_value_next = wrapped[19:0];
                        kind               = asfp_pkg::KIND_COMPASS;
                    end else if (is_ps) begin
                        play_state_next = hdr;
                        kind            = asfp_pkg::KIND_PLAY;
                    end else begin
                        kind = asfp_pkg::KIND_NONE;
                    end
                    done = (kind != asfp_pkg::KIND_NONE);
                end
            end
        end
    end

    always_comb begin
        result.frame_done     = done;
        result.frame_kind     = kind;
        result.x_coord        = x_value_next;
        result.y_coord        = y_value_next;
        result.heading_tenths = heading_value_next;
        result.game_state     = play_state_next;
        result.ball_in_window =
            (17'(x_value_next) < $signed({7'd0, cfg.window_x_high})) &&
            (17'(x_value_next) > $signed({7'd0, cfg.window_x_low}))  &&
            (17'(y_value_next) < $signed({7'd0, cfg.window_y_high})) &&
            (17'(y_value_next) > $signed({7'd0, cfg.window_y_low}));
    end

    always_ff @(posedge aclk) begin
        if (accept && !command) begin
            frame_bytes_reg[wr_index] <= rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg      <= 3'd0;
            frame_length_reg    <= 3'd0;
            x_value_reg         <= 16'sd0;
            y_value_reg         <= 16'sd0;
            heading_value_reg   <= 20'sd0;
            raw_heading_reg     <= 19'sd0;
            captured_offset_reg <= 19'sd0;
            play_state_reg      <= 8'd0;
        end else begin
            byte_count_reg      <= byte_count_next;
            frame_length_reg    <= frame_length_next;
            x_value_reg         <= x_value_next;
            y_value_reg         <= y_value_next;
            heading_value_reg   <= heading_value_next;
            raw_heading_reg     <= raw_heading_next;
            captured_offset_reg <= captured_offset_next;
            play_state_reg      <= play_state_next;
        end
    end

endmodule

// File: hdl/asfp_out_reg.sv
`timescale 1ns / 1ps
// Result register with valid/ready handshake toward the result channel.
// Depends on asfp_pkg for result_t.

module asfp_out_reg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  asfp_pkg::result_t    in_result,
    output logic                 out_valid,
    input  logic                 out_ready,
    output asfp_pkg::result_t    out_result
);

    logic              valid_reg;
    logic              valid_next;
    asfp_pkg::result_t result_reg;

    assign in_ready   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_comb begin
        valid_next = valid_reg;
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            result_reg <= in_result;
        end
    end

endmodule

// File: hdl/ascii_sensor_frame_parser_top.sv
`timescale 1ns / 1ps
// Top level of the ASCII sensor frame parser: config registers, parser, result register.
// Depends on asfp_pkg, asfp_cfg_regs, asfp_parser and asfp_out_reg.

// The parser takes one request per clock cycle while the result channel is ready and
// returns exactly one result per request, in the cycle after it is accepted; a request
// is taken in the same cycle in which the previous result leaves, so the sustained rate
// is one item per cycle unless m_tready stalls. The result register is the single
// register stage after the input handshake; all framing, digit decode, heading
// correction and window compare are done combinationally in front of it. Configuration
// writes are taken in every cycle and should be made only while no request is in flight.

module ascii_sensor_frame_parser_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // Fields from bit 0: rx_byte[7:0].
    input  logic [7:0]                         s_tdata,
    // Fields from bit 0: command[0].
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // Fields from bit 0: x_coord[15:0], y_coord[31:16], heading_tenths[51:32],
    // game_state[59:52], ball_in_window[60], zero fill [63:61].
    output logic [63:0]                        m_tdata,
    output logic                               m_tlast,
    // Fields from bit 0: frame_kind[2:0].
    output logic [2:0]                         m_tuser,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [asfp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [asfp_pkg::CFG_DATA_W-1:0]    cfg_data
);

    asfp_pkg::cfg_t    cfg;
    asfp_pkg::result_t parsed;
    asfp_pkg::result_t delivered;
    logic              accept;

    assign accept = s_tvalid && s_tready;

    asfp_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    asfp_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .command (s_tuser),
        .rx_byte (s_tdata),
        .cfg     (cfg),
        .result  (parsed)
    );

    asfp_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_result  (parsed),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (delivered)
    );

    assign m_tdata = {3'd0,
                      delivered.ball_in_window,
                      delivered.game_state,
                      delivered.heading_tenths,
                      delivered.y_coord,
                      delivered.x_coord};
    assign m_tlast = delivered.frame_done;
    assign m_tuser = delivered.frame_kind;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for ascii_sensor_frame_parser_top. It sends byte and capture
// requests, predicts each result in a scoreboard class and compares it field by field.
// Depends on asfp_pkg and the RTL of the block; it reads no files.

module testbench;

    localparam int ITEM_GOAL    = 1050;
    localparam int PHASES       = 6;
    localparam int DRAIN_CYCLES = 4;
    localparam int TIMEOUT_NS   = 2_000_000;
    localparam int CFG_W        = asfp_pkg::CFG_DATA_W;
    localparam int IDX_W        = asfp_pkg::CFG_INDEX_W;

    class frame_scoreboard;
        logic [11:0]        heading_offset;
        logic [9:0]         win_x_low;
        logic [9:0]         win_x_high;
        logic [9:0]         win_y_low;
        logic [9:0]         win_y_high;
        logic [7:0]         frame_bytes [asfp_pkg::FRAME_DEPTH];
        logic [2:0]         byte_count;
        logic [2:0]         frame_length;
        logic signed [15:0] x_value;
        logic signed [15:0] y_value;
        logic signed [19:0] heading_value;
        logic signed [18:0] raw_heading;
        logic signed [18:0] captured_offset;
        logic [7:0]         play_state;
        asfp_pkg::result_t  expected_q [$];
        int                 errors;
        int                 results_seen;
        int                 captures;
        int                 in_window;
        int                 kind_count [5];

        function void restart();
            heading_offset  = '0;
            win_x_low       = asfp_pkg::RST_WINDOW_X_LOW;
            win_x_high      = asfp_pkg::RST_WINDOW_X_HIGH;
            win_y_low       = asfp_pkg::RST_WINDOW_Y_LOW;
            win_y_high      = asfp_pkg::RST_WINDOW_Y_HIGH;
            foreach (frame_bytes[i]) frame_bytes[i] = '0;
            byte_count      = '0;
            frame_length    = '0;
            x_value         = '0;
            y_value         = '0;
            heading_value   = '0;
            raw_heading     = '0;
            captured_offset = '0;
            play_state      = '0;
            errors          = 0;
            results_seen    = 0;
            captures        = 0;
            in_window       = 0;
            foreach (kind_count[i]) kind_count[i] = 0;
        endfunction

        function void set_reg(asfp_pkg::reg_index_t idx, logic [CFG_W-1:0] value);
            case (idx)
                asfp_pkg::REG_HEADING_OFFSET: heading_offset = value;
                asfp_pkg::REG_WINDOW_X_LOW:   win_x_low = value[9:0];
                asfp_pkg::REG_WINDOW_X_HIGH:  win_x_high = value[9:0];
                asfp_pkg::REG_WINDOW_Y_LOW:   win_y_low = value[9:0];
                asfp_pkg::REG_WINDOW_Y_HIGH:  win_y_high = value[9:0];
                default: ;
            endcase
        endfunction

        function int digit(int idx);
            return int'(frame_bytes[idx]) - int'(asfp_pkg::DIGIT_ZERO);
        endfunction

        function int three_digits();
            return 100 * digit(1) + 10 * digit(2) + digit(3);
        endfunction

        function void note_request(logic command, logic [7:0] rx_byte);
            logic [7:0]        hdr;
            asfp_pkg::kind_t   kind;
            int                turn;
            asfp_pkg::result_t want;
            kind = asfp_pkg::KIND_NONE;
            if (command) begin
                captured_offset = raw_heading;
                captures++;
            end else begin
                frame_bytes[byte_count % asfp_pkg::FRAME_DEPTH] = rx_byte;
                hdr = frame_bytes[0];
                if (hdr == asfp_pkg::HDR_X || hdr == asfp_pkg::HDR_Y) begin
                    frame_length = asfp_pkg::LEN_XY;
                    byte_count++;
                end else if (hdr == asfp_pkg::HDR_C) begin
                    frame_length = asfp_pkg::LEN_C;
                    byte_count++;
                end else if (hdr == asfp_pkg::HDR_P || hdr == asfp_pkg::HDR_S) begin
                    frame_length = asfp_pkg::LEN_PS;
                    byte_count++;
                end
                if (byte_count == frame_length) begin
                    if (hdr == asfp_pkg::HDR_X) begin
                        x_value = three_digits();
                        kind = asfp_pkg::KIND_X;
                    end else if (hdr == asfp_pkg::HDR_Y) begin
                        y_value = three_digits();
                        kind = asfp_pkg::KIND_Y;
                    end else if (hdr == asfp_pkg::HDR_C) begin
                        turn = 10 * three_digits() + digit(4);
                        raw_heading = turn;
                        turn = turn - int'(heading_offset) - int'(captured_offset);
                        // The heading wraps by one full turn at most, in either direction.
                        if (turn < 0) begin
                            turn += asfp_pkg::FULL_TURN;
                        end else if (turn > asfp_pkg::FULL_TURN) begin
                            turn -= asfp_pkg::FULL_TURN;
                        end
                        heading_value = turn;
                        kind = asfp_pkg::KIND_COMPASS;
                    end else if (hdr == asfp_pkg::HDR_P || hdr == asfp_pkg::HDR_S) begin
                        play_state = hdr;
                        kind = asfp_pkg::KIND_PLAY;
                    end
                    byte_count = '0;
                end
            end
            want.frame_done     = (kind != asfp_pkg::KIND_NONE);
            want.frame_kind     = kind;
            want.x_coord        = x_value;
            want.y_coord        = y_value;
            want.heading_tenths = heading_value;
            want.game_state     = play_state;
            want.ball_in_window = int'(x_value) < int'(win_x_high)
                               && int'(x_value) > int'(win_x_low)
                               && int'(y_value) < int'(win_y_high)
                               && int'(y_value) > int'(win_y_low);
            expected_q.push_back(want);
        endfunction

        task report_mismatch(string field, logic signed [31:0] want, logic signed [31:0] got);
            errors++;
            if (errors <= 30) begin
                $display("Mismatch on result %0d, %s: expected %0d, got %0d",
                         results_seen, field, want, got);
            end
        endtask

        task check_field(string field, logic signed [31:0] want, logic signed [31:0] got);
            if (want !== got) begin
                report_mismatch(field, want, got);
            end
        endtask

        task check_result(logic [63:0] data, logic [2:0] user, logic last);
            asfp_pkg::result_t want;
            results_seen++;
            if (expected_q.size() == 0) begin
                report_mismatch("result with no request pending", 0, 0);
            end else begin
                want = expected_q.pop_front();
                if (want.ball_in_window) in_window++;
                if (want.frame_done) kind_count[want.frame_kind]++;
                check_field("frame_done", want.frame_done, last);
                check_field("frame_kind", want.frame_kind, user);
                check_field("x_coord", want.x_coord, $signed(data[15:0]));
                check_field("y_coord", want.y_coord, $signed(data[31:16]));
                check_field("heading_tenths", want.heading_tenths, $signed(data[51:32]));
                check_field("game_state", want.game_state, data[59:52]);
                check_field("ball_in_window", want.ball_in_window, data[60]);
            end
        endtask
    endclass

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata   = '0;
    logic              s_tuser   = 1'b0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [63:0]       m_tdata;
    logic              m_tlast;
    logic [2:0]        m_tuser;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]  cfg_data  = '0;

    frame_scoreboard sb = new;
    bit gaps_on   = 1'b1;
    bit stalls_on = 1'b1;
    int stall_left = 0;
    int sent = 0;
    int settings_used = 1;

    ascii_sensor_frame_parser_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("ascii_sensor_frame_parser_top test failed");
        $finish;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (stalls_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 6);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_item(logic command, logic [7:0] rx_byte);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= command;
        s_tdata  <= rx_byte;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(command, rx_byte);
        sent++;
    endtask

    task automatic write_reg(asfp_pkg::reg_index_t idx, logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, value);
    endtask

    task automatic apply_config(int offset, int xl, int xh, int yl, int yh);
        write_reg(asfp_pkg::REG_HEADING_OFFSET, CFG_W'(offset));
        write_reg(asfp_pkg::REG_WINDOW_X_LOW, CFG_W'(xl));
        write_reg(asfp_pkg::REG_WINDOW_X_HIGH, CFG_W'(xh));
        write_reg(asfp_pkg::REG_WINDOW_Y_LOW, CFG_W'(yl));
        write_reg(asfp_pkg::REG_WINDOW_Y_HIGH, CFG_W'(yh));
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [7:0] digit_char(int value);
        return asfp_pkg::DIGIT_ZERO + 8'(value);
    endfunction

    function automatic int pick_near(int lo, int hi);
        int a;
        int b;
        a = ((lo < hi) ? lo : hi) - 2;
        b = ((lo < hi) ? hi : lo) + 2;
        if (a < 0) a = 0;
        if (b > 999) b = 999;
        return $urandom_range(a, b);
    endfunction

    // Digits go out most significant first; now and then one is replaced by a raw byte.
    task automatic send_digits(int value, int count);
        int div;
        div = (count == 4) ? 1000 : 100;
        repeat (count) begin
            if ($urandom_range(0, 11) == 0) begin
                send_item(1'b0, 8'($urandom));
            end else begin
                send_item(1'b0, digit_char((value / div) % 10));
            end
            div /= 10;
        end
    endtask

    task automatic send_frame();
        int pick;
        int value;
        int target;
        pick = $urandom_range(0, 99);
        if (pick < 22) begin
            send_item(1'b0, asfp_pkg::HDR_X);
            value = $urandom_range(0, 1) ? pick_near(int'(sb.win_x_low), int'(sb.win_x_high))
                                         : $urandom_range(0, 999);
            send_digits(value, 3);
        end else if (pick < 44) begin
            send_item(1'b0, asfp_pkg::HDR_Y);
            value = $urandom_range(0, 1) ? pick_near(int'(sb.win_y_low), int'(sb.win_y_high))
                                         : $urandom_range(0, 999);
            send_digits(value, 3);
        end else if (pick < 78) begin
            send_item(1'b0, asfp_pkg::HDR_C);
            value = $urandom_range(0, 9999);
            // Aim some readings at the edges of the heading wrap.
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 5))
                    0: target = 0;
                    1: target = asfp_pkg::FULL_TURN;
                    2: target = -1;
                    3: target = asfp_pkg::FULL_TURN + 1;
                    4: target = 1;
                    default: target = asfp_pkg::FULL_TURN - 1;
                endcase
                target = target + int'(sb.heading_offset) + int'(sb.captured_offset);
                if (target >= 0 && target <= 9999) value = target;
            end
            send_digits(value, 4);
        end else begin
            send_item(1'b0, (pick < 89) ? asfp_pkg::HDR_P : asfp_pkg::HDR_S);
        end
    endtask

    task automatic send_unit();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 72) begin
            send_frame();
        end else if (pick < 84) begin
            send_item(1'b0, 8'($urandom));
        end else if (pick < 92) begin
            send_item(1'b1, 8'($urandom));
        end else begin
            // A cut-off frame; whatever follows fills its remaining bytes.
            send_item(1'b0, $urandom_range(0, 1) ? asfp_pkg::HDR_X : asfp_pkg::HDR_C);
            repeat ($urandom_range(1, 2)) send_item(1'b0, digit_char($urandom_range(0, 9)));
        end
    endtask

    initial begin
        int xl;
        int yl;
        sb.restart();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        send_item(1'b0, 8'h00);
        send_item(1'b0, asfp_pkg::HDR_X);
        repeat (3) send_item(1'b0, 8'hFF);
        send_item(1'b0, asfp_pkg::HDR_Y);
        repeat (3) send_item(1'b0, 8'h00);
        send_item(1'b0, asfp_pkg::HDR_C);
        repeat (4) send_item(1'b0, digit_char(9));
        send_item(1'b1, 8'hFF);
        send_item(1'b0, asfp_pkg::HDR_C);
        send_item(1'b0, digit_char(3));
        send_item(1'b0, digit_char(6));
        send_item(1'b0, digit_char(0));
        send_item(1'b0, digit_char(0));
        send_item(1'b0, asfp_pkg::HDR_P);
        send_item(1'b0, asfp_pkg::HDR_S);

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                drain();
                xl = $urandom_range(0, 940);
                yl = $urandom_range(0, 940);
                case (phase)
                    1: apply_config(0, 0, 999, 0, 999);
                    2: apply_config(asfp_pkg::FULL_TURN - 1, 999, 0, 999, 0);
                    PHASES - 1: begin
                        gaps_on   = 1'b0;
                        stalls_on = 1'b0;
                        apply_config($urandom_range(0, asfp_pkg::FULL_TURN - 1),
                                     asfp_pkg::RST_WINDOW_X_LOW, asfp_pkg::RST_WINDOW_X_HIGH,
                                     asfp_pkg::RST_WINDOW_Y_LOW, asfp_pkg::RST_WINDOW_Y_HIGH);
                    end
                    default: apply_config($urandom_range(0, asfp_pkg::FULL_TURN - 1),
                                          xl, xl + $urandom_range(1, 59),
                                          yl, yl + $urandom_range(1, 59));
                endcase
            end
            while (sent < (phase + 1) * ITEM_GOAL / PHASES) send_unit();
        end
        drain();

        $display("Sent %0d requests under %0d register settings;",
                 sent, settings_used);
        $display("%0d results checked, %0d in window.", sb.results_seen, sb.in_window);
        $display("Frames done: %0d X, %0d Y, %0d compass, %0d play/stop; %0d captures.",
                 sb.kind_count[asfp_pkg::KIND_X], sb.kind_count[asfp_pkg::KIND_Y],
                 sb.kind_count[asfp_pkg::KIND_COMPASS], sb.kind_count[asfp_pkg::KIND_PLAY],
                 sb.captures);
        if (sb.errors == 0) begin
            $display("ascii_sensor_frame_parser_top test passed");
        end else begin
            $display("ascii_sensor_frame_parser_top test failed");
        end
        $finish;
    end

endmodule
